/* rtl/ppdec_pkg.sv */
// ppdec_pkg: shared widths, command/result codes and divide-by-ten constants
// for the polyline point decoder. No dependencies.
package ppdec_pkg;

  localparam int CMD_W    = 2;
  localparam int CHAR_W   = 8;
  localparam int KIND_W   = 2;
  localparam int ANCHOR_W = 32;
  localparam int DELTA_W  = 16;

  localparam int COORD_BITS_DEFAULT = 32;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_CHAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_START = 2'd1;
  localparam logic [CMD_W-1:0] CMD_END   = 2'd2;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_POINT       = 2'd0;
  localparam logic [KIND_W-1:0] KIND_END_CLEAN   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END_PARTIAL = 2'd2;

  // Character decoding
  localparam logic [CHAR_W-1:0] CHAR_BIAS     = 8'd63;
  localparam logic [CHAR_W-1:0] CHAR_CONTINUE = 8'd95;  // bias + 0x20
  localparam int                GROUP_BITS    = 5;
  localparam logic [2:0]        GROUP_LAST    = 3'd7;   // saturation / drop index

  // Unsigned 32-bit divide by ten: q = (x * RECIP) >> SHIFT, exact
  localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
  localparam int          DIV10_SHIFT = 35;

  // Sign-folded value to signed value
  function automatic logic [31:0] unfold(input logic [31:0] v);
    logic [31:0] h;
    h = {v[31], v[31:1]};
    return v[0] ? ~h : h;
  endfunction

endpackage

/* rtl/ppdec_if.sv */
// ppdec_in_if / ppdec_out_if: valid/ready channels for characters and results.
// Depends on ppdec_pkg.
interface ppdec_in_if import ppdec_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [CHAR_W-1:0] char_code;

  modport source (output valid, command, char_code, input ready);
  modport sink   (input valid, command, char_code, output ready);
endinterface

interface ppdec_out_if import ppdec_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [KIND_W-1:0]          result_kind;
  logic                       is_anchor;
  logic signed [ANCHOR_W-1:0] anchor_lat;
  logic signed [ANCHOR_W-1:0] anchor_lon;
  logic signed [DELTA_W-1:0]  delta_lat;
  logic signed [DELTA_W-1:0]  delta_lon;

  modport source (output valid, result_kind, is_anchor, anchor_lat, anchor_lon,
                  delta_lat, delta_lon, input ready);
  modport sink   (input valid, result_kind, is_anchor, anchor_lat, anchor_lon,
                  delta_lat, delta_lon, output ready);
endinterface

/* rtl/polyline_point_decoder.sv */
// polyline_point_decoder: encoded polyline character stream to anchor/delta points.
// A result passes through stage 1, stage 2 and stage 3 (the output register).
// Throughput: one item per cycle unless output stalls; a full stage waits on the next one.
// Reset (rst, synchronous): decoder state cleared, anchor pending, all stages empty.
// Depends on ppdec_pkg and ppdec_in_if / ppdec_out_if.
module polyline_point_decoder import ppdec_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  ppdec_in_if.sink     chars,
  ppdec_out_if.source  results
);

  // ---------------------------------------------------------------------------
  // Decoder state, updated as each item is taken
  // ---------------------------------------------------------------------------
  logic [31:0]                  partial_value;
  logic [2:0]                   group_shift;
  logic                         decoding_lon;
  logic signed [COORD_BITS-1:0] pending_lat;
  logic signed [COORD_BITS-1:0] running_lat;
  logic signed [COORD_BITS-1:0] running_lon;
  logic                         awaiting_first;

  logic [31:0]                  partial_value_next;
  logic [2:0]                   group_shift_next;
  logic                         decoding_lon_next;
  logic signed [COORD_BITS-1:0] pending_lat_next;
  logic signed [COORD_BITS-1:0] running_lat_next;
  logic signed [COORD_BITS-1:0] running_lon_next;
  logic                         awaiting_first_next;

  // Stage 1: result kind and committed coordinates
  logic                         s1_valid;
  logic [KIND_W-1:0]            s1_kind;
  logic                         s1_anchor;
  logic signed [COORD_BITS-1:0] s1_lat;
  logic signed [COORD_BITS-1:0] s1_lon;

  logic                         res_valid;
  logic [KIND_W-1:0]            res_kind;
  logic                         res_anchor;

  // Stage 2: divide-by-ten quotients (low 16 bits, magnitude + sign)
  logic                         s2_valid;
  logic [KIND_W-1:0]            s2_kind;
  logic                         s2_anchor;
  logic signed [ANCHOR_W-1:0]   s2_abs_lat;
  logic signed [ANCHOR_W-1:0]   s2_abs_lon;
  logic [DELTA_W-1:0]           s2_q_lat;
  logic [DELTA_W-1:0]           s2_q_lon;
  logic                         s2_neg_lat;
  logic                         s2_neg_lon;

  // Stage 3: output register, plus previous coarse point (low 16 bits suffice)
  logic                         s3_valid;
  logic [KIND_W-1:0]            s3_kind;
  logic                         s3_anchor;
  logic signed [ANCHOR_W-1:0]   s3_abs_lat;
  logic signed [ANCHOR_W-1:0]   s3_abs_lon;
  logic signed [DELTA_W-1:0]    s3_delta_lat;
  logic signed [DELTA_W-1:0]    s3_delta_lon;
  logic [DELTA_W-1:0]           previous_lat_coarse;
  logic [DELTA_W-1:0]           previous_lon_coarse;

  logic adv3, ready2, ready1, in_take;

  // Stage handshake: a stage loads when it is empty or its content moves on
  assign adv3         = !s3_valid || results.ready;
  assign ready2       = !s2_valid || adv3;
  assign ready1       = !s1_valid || ready2;
  assign chars.ready  = ready1;
  assign in_take      = chars.valid && ready1;

  // ---------------------------------------------------------------------------
  // Character decode and coordinate accumulation
  // ---------------------------------------------------------------------------
  logic [CHAR_W-1:0]     char_diff;
  logic [GROUP_BITS-1:0] grp;
  logic                  more;
  logic [5:0]            pos;
  logic [31:0]           partial_ins;
  logic [31:0]           value;

  always_comb begin
    char_diff   = chars.char_code - CHAR_BIAS;
    grp         = char_diff[GROUP_BITS-1:0];
    more        = chars.char_code >= CHAR_CONTINUE;
    pos         = 6'(group_shift) * 6'd5;
    // group at position 30 keeps its low two bits; index 7 (position 35) is dropped
    partial_ins = partial_value;
    if (group_shift != GROUP_LAST) begin
      partial_ins = partial_value | ({{(32-GROUP_BITS){1'b0}}, grp} << pos);
    end
    value = unfold(partial_ins);
  end

  always_comb begin
    partial_value_next  = partial_value;
    group_shift_next    = group_shift;
    decoding_lon_next   = decoding_lon;
    pending_lat_next    = pending_lat;
    running_lat_next    = running_lat;
    running_lon_next    = running_lon;
    awaiting_first_next = awaiting_first;
    res_valid           = 1'b0;
    res_kind            = KIND_POINT;
    res_anchor          = 1'b0;

    unique case (chars.command)
      CMD_START, CMD_END: begin
        // report the route end (clean or partial), then start a fresh route
        res_valid           = 1'b1;
        res_kind            = (group_shift != 3'd0 || decoding_lon) ?
                              KIND_END_PARTIAL : KIND_END_CLEAN;
        partial_value_next  = '0;
        group_shift_next    = '0;
        decoding_lon_next   = 1'b0;
        pending_lat_next    = '0;
        running_lat_next    = '0;
        running_lon_next    = '0;
        awaiting_first_next = 1'b1;
      end
      CMD_CHAR: begin
        if (more) begin
          partial_value_next = partial_ins;
          if (group_shift != GROUP_LAST) begin
            group_shift_next = group_shift + 3'd1;
          end
        end else begin
          partial_value_next = '0;
          group_shift_next   = '0;
          if (!decoding_lon) begin
            pending_lat_next  = running_lat + value[COORD_BITS-1:0];
            decoding_lon_next = 1'b1;
          end else begin
            // longitude done: commit both coordinates and emit a point
            decoding_lon_next   = 1'b0;
            running_lat_next    = pending_lat;
            running_lon_next    = running_lon + value[COORD_BITS-1:0];
            res_valid           = 1'b1;
            res_anchor          = awaiting_first;
            awaiting_first_next = 1'b0;
          end
        end
      end
      default: begin
        // unused command code: no effect
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_value  <= '0;
      group_shift    <= '0;
      decoding_lon   <= 1'b0;
      pending_lat    <= '0;
      running_lat    <= '0;
      running_lon    <= '0;
      awaiting_first <= 1'b1;
      s1_valid       <= 1'b0;
    end else begin
      if (in_take) begin
        partial_value  <= partial_value_next;
        group_shift    <= group_shift_next;
        decoding_lon   <= decoding_lon_next;
        pending_lat    <= pending_lat_next;
        running_lat    <= running_lat_next;
        running_lon    <= running_lon_next;
        awaiting_first <= awaiting_first_next;
        s1_valid       <= res_valid;
      end else if (s1_valid && ready2) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_kind   <= res_kind;
      s1_anchor <= res_anchor;
      s1_lat    <= running_lat_next;
      s1_lon    <= running_lon_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: truncating divide by ten via reciprocal multiply on the magnitude
  // ---------------------------------------------------------------------------
  logic signed [ANCHOR_W-1:0] lat_ext, lon_ext;
  logic [31:0]                mag_lat, mag_lon;
  logic [63:0]                prod_lat, prod_lon;

  always_comb begin
    lat_ext  = ANCHOR_W'(s1_lat);
    lon_ext  = ANCHOR_W'(s1_lon);
    mag_lat  = lat_ext[ANCHOR_W-1] ? 32'(-lat_ext) : 32'(lat_ext);
    mag_lon  = lon_ext[ANCHOR_W-1] ? 32'(-lon_ext) : 32'(lon_ext);
    prod_lat = 64'(mag_lat) * 64'(DIV10_RECIP);
    prod_lon = 64'(mag_lon) * 64'(DIV10_RECIP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (ready2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2) begin
      s2_kind    <= s1_kind;
      s2_anchor  <= s1_anchor;
      s2_abs_lat <= lat_ext;
      s2_abs_lon <= lon_ext;
      s2_q_lat   <= prod_lat[DIV10_SHIFT+DELTA_W-1:DIV10_SHIFT];
      s2_q_lon   <= prod_lon[DIV10_SHIFT+DELTA_W-1:DIV10_SHIFT];
      s2_neg_lat <= lat_ext[ANCHOR_W-1];
      s2_neg_lon <= lon_ext[ANCHOR_W-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: restore sign, difference against previous point, output register
  // ---------------------------------------------------------------------------
  logic [DELTA_W-1:0] coarse_lat, coarse_lon;
  logic               is_point;

  always_comb begin
    coarse_lat = s2_neg_lat ? -s2_q_lat : s2_q_lat;
    coarse_lon = s2_neg_lon ? -s2_q_lon : s2_q_lon;
    is_point   = s2_kind == KIND_POINT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv3) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      s3_kind      <= s2_kind;
      s3_anchor    <= is_point && s2_anchor;
      s3_abs_lat   <= (is_point && s2_anchor) ? s2_abs_lat : '0;
      s3_abs_lon   <= (is_point && s2_anchor) ? s2_abs_lon : '0;
      s3_delta_lat <= (is_point && !s2_anchor) ? coarse_lat - previous_lat_coarse : '0;
      s3_delta_lon <= (is_point && !s2_anchor) ? coarse_lon - previous_lon_coarse : '0;
      if (s2_valid && is_point) begin
        previous_lat_coarse <= coarse_lat;
        previous_lon_coarse <= coarse_lon;
      end
    end
  end

  assign results.valid       = s3_valid;
  assign results.result_kind = s3_kind;
  assign results.is_anchor   = s3_anchor;
  assign results.anchor_lat  = s3_abs_lat;
  assign results.anchor_lon  = s3_abs_lon;
  assign results.delta_lat   = s3_delta_lat;
  assign results.delta_lon   = s3_delta_lon;

endmodule
